### src/weighted_four_level_priority_queue_defines.svh
// Assertion macros for the weighted four-level priority queue.
// Used by the top level only; no other dependencies.
`ifndef WEIGHTED_FOUR_LEVEL_PRIORITY_QUEUE_DEFINES_SVH
`define WEIGHTED_FOUR_LEVEL_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define WFPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wfpq assertion failed");
// Next-cycle implication.
`define WFPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wfpq assertion failed");
`else
`define WFPQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define WFPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/wfpq_pkg.sv
// Package for the weighted four-level priority queue.
// Holds the opcode and class codes and the credit constants; no dependencies.
`timescale 1ns / 1ps

package wfpq_pkg;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CLS_LOW     = 2'd0,
        CLS_NORMAL  = 2'd1,
        CLS_HIGH    = 2'd2,
        CLS_HIGHEST = 2'd3
    } cls_t;

    localparam int unsigned NUM_CLASSES = 4;
    localparam int unsigned CREDIT_W    = 8;
    localparam logic [CREDIT_W-1:0] CREDIT_RESET = 8'd5;

endpackage

### src/weighted_four_level_priority_queue.sv
// Top level of the weighted four-level priority queue scheduler.
// Depends on wfpq_pkg and weighted_four_level_priority_queue_defines.svh.
`timescale 1ns / 1ps

`include "weighted_four_level_priority_queue_defines.svh"

// Four FIFO classes of message tags share one tag memory with a registered
// read port; head pointers, fill counts and burst credits sit in flops. An
// operation is taken at every clock edge with start high (busy is never
// raised), so the block sustains one push, pop or clear per cycle. Each
// accepted operation yields exactly one result, marked by done in the cycle
// right after acceptance; a popped tag comes straight from the memory read
// register, read at the accepting edge. The receiver cannot stall: results
// must be sampled in their done cycle. No clearing pass is needed after reset.
module weighted_four_level_priority_queue #(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned TAG_WIDTH   = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            opcode,
    input  logic [TAG_WIDTH-1:0]                  message_tag,
    input  logic [3:0]                            priority_flags,
    input  logic                                  cfg_we,
    input  logic [wfpq_pkg::CREDIT_W-1:0]         cfg_wdata,
    output logic                                  done,
    output logic                                  pop_valid,
    output logic [TAG_WIDTH-1:0]                  popped_tag,
    output logic [1:0]                            popped_class,
    output logic                                  push_accepted,
    output logic [$clog2(4*QUEUE_DEPTH+1)-1:0]    total_count
);

    import wfpq_pkg::*;

    localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SUM_W  = PTR_W + 1;
    localparam int unsigned ADDR_W = PTR_W + 2;
    localparam int unsigned CNT_W  = $clog2(4 * QUEUE_DEPTH + 1);
    localparam int unsigned MEM_DEPTH = 4 << PTR_W;
    localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0]  DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

    // Tag memory
    logic [TAG_WIDTH-1:0] mem [MEM_DEPTH];
    logic [TAG_WIDTH-1:0] rd_data_reg;

    // Queue state
    logic [PTR_W-1:0]    head_reg [NUM_CLASSES];
    logic [FILL_W-1:0]   fill_reg [NUM_CLASSES];
    logic [CNT_W-1:0]    total_reg;
    logic [CREDIT_W-1:0] burst_reg;
    logic [CREDIT_W-1:0] hst_crd_reg, hst_crd_next;
    logic [CREDIT_W-1:0] hi_crd_reg, hi_crd_next;
    logic [CREDIT_W-1:0] nrm_crd_reg, nrm_crd_next;

    // Result registers
    logic       done_reg;
    logic       pop_valid_reg;
    logic [1:0] pop_cls_reg;
    logic       push_acc_reg;

    // Decode
    op_t              op;
    logic             accept;
    logic             do_push;
    logic             do_pop;
    logic             do_clear;
    logic             push_hit;
    cls_t             push_cls;
    logic             push_ok;
    logic [SUM_W-1:0] tail_sum;
    logic [PTR_W-1:0] tail_ptr;
    logic             srv_valid;
    cls_t             srv_cls;
    logic [PTR_W-1:0] srv_head;
    logic [PTR_W-1:0] srv_head_next;
    logic             hst_ok;
    logic             hi_ok;
    logic             nrm_ok;

    assign busy = 1'b0;

    always_comb
    begin
        op       = op_t'(opcode);
        accept   = start && !busy;
        do_push  = accept && (op == OP_PUSH);
        do_pop   = accept && (op == OP_POP);
        do_clear = accept && (op == OP_CLEAR);

        // Lowest set flag wins
        push_hit = 1'b1;
        push_cls = CLS_LOW;
        priority if (priority_flags[0])
            push_cls = CLS_LOW;
        else if (priority_flags[1])
            push_cls = CLS_NORMAL;
        else if (priority_flags[2])
            push_cls = CLS_HIGH;
        else if (priority_flags[3])
            push_cls = CLS_HIGHEST;
        else
            push_hit = 1'b0;

        push_ok  = push_hit && (fill_reg[push_cls] != FULL_FILL);
        tail_sum = SUM_W'(head_reg[push_cls]) + SUM_W'(fill_reg[push_cls]);
        tail_ptr = (tail_sum >= DEPTH_SUM) ? PTR_W'(tail_sum - DEPTH_SUM)
                                           : PTR_W'(tail_sum);
    end

    // Class selection and credit update for a pop
    always_comb
    begin
        hst_ok = (hst_crd_reg != '0) && (fill_reg[CLS_HIGHEST] != '0);
        hi_ok  = (hi_crd_reg  != '0) && (fill_reg[CLS_HIGH]    != '0);
        nrm_ok = (nrm_crd_reg != '0) && (fill_reg[CLS_NORMAL]  != '0);

        srv_valid    = 1'b1;
        srv_cls      = CLS_LOW;
        hst_crd_next = hst_crd_reg;
        hi_crd_next  = hi_crd_reg;
        nrm_crd_next = nrm_crd_reg;

        priority if (hst_ok)
        begin
            srv_cls      = CLS_HIGHEST;
            hst_crd_next = hst_crd_reg - 1'b1;
        end
        else if (hi_ok)
        begin
            srv_cls      = CLS_HIGH;
            hst_crd_next = burst_reg;
            hi_crd_next  = hi_crd_reg - 1'b1;
        end
        else if (nrm_ok)
        begin
            srv_cls      = CLS_NORMAL;
            hst_crd_next = burst_reg;
            hi_crd_next  = burst_reg;
            nrm_crd_next = nrm_crd_reg - 1'b1;
        end
        else
        begin
            // No credited class eligible: restore all, serve low, else retry upper
            hst_crd_next = burst_reg;
            hi_crd_next  = burst_reg;
            nrm_crd_next = burst_reg;
            priority if (fill_reg[CLS_LOW] != '0)
                srv_cls = CLS_LOW;
            else if (fill_reg[CLS_HIGHEST] != '0)
            begin
                srv_cls      = CLS_HIGHEST;
                hst_crd_next = burst_reg - 1'b1;
            end
            else if (fill_reg[CLS_HIGH] != '0)
            begin
                srv_cls     = CLS_HIGH;
                hi_crd_next = burst_reg - 1'b1;
            end
            else if (fill_reg[CLS_NORMAL] != '0)
            begin
                srv_cls      = CLS_NORMAL;
                nrm_crd_next = burst_reg - 1'b1;
            end
            else
                srv_valid = 1'b0;
        end

        srv_head      = head_reg[srv_cls];
        srv_head_next = (srv_head == LAST_PTR) ? '0 : srv_head + 1'b1;
    end

    // Tag memory: write on push, registered read on pop
    always_ff @(posedge clk)
    begin
        if (do_push && push_ok)
            mem[{push_cls, tail_ptr}] <= message_tag;
        if (do_pop && srv_valid)
            rd_data_reg <= mem[ADDR_W'({srv_cls, srv_head})];
    end

    // Queue pointers, fills, occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else if (do_clear)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else if (do_push && push_ok)
        begin
            fill_reg[push_cls] <= fill_reg[push_cls] + 1'b1;
            total_reg          <= total_reg + 1'b1;
        end
        else if (do_pop && srv_valid)
        begin
            head_reg[srv_cls] <= srv_head_next;
            fill_reg[srv_cls] <= fill_reg[srv_cls] - 1'b1;
            total_reg         <= total_reg - 1'b1;
        end
    end

    // Burst credit register and running credits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_reg   <= CREDIT_RESET;
            hst_crd_reg <= CREDIT_RESET;
            hi_crd_reg  <= CREDIT_RESET;
            nrm_crd_reg <= CREDIT_RESET;
        end
        else
        begin
            if (cfg_we)
                burst_reg <= (cfg_wdata == '0) ? CREDIT_W'(1) : cfg_wdata;
            if (do_pop)
            begin
                hst_crd_reg <= hst_crd_next;
                hi_crd_reg  <= hi_crd_next;
                nrm_crd_reg <= nrm_crd_next;
            end
        end
    end

    // Result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 1'b0;
            pop_valid_reg <= 1'b0;
            pop_cls_reg   <= '0;
            push_acc_reg  <= 1'b0;
        end
        else
        begin
            done_reg      <= accept;
            pop_valid_reg <= do_pop && srv_valid;
            pop_cls_reg   <= (do_pop && srv_valid) ? srv_cls : CLS_LOW;
            push_acc_reg  <= do_push && push_ok;
        end
    end

    assign done          = done_reg;
    assign pop_valid     = pop_valid_reg;
    assign popped_tag    = pop_valid_reg ? rd_data_reg : '0;
    assign popped_class  = pop_cls_reg;
    assign push_accepted = push_acc_reg;
    assign total_count   = total_reg;

    `WFPQ_ASSERT_NEXT(a_one_result, clk, rst_n, accept, done)
    `WFPQ_ASSERT_NEXT(a_no_spurious_result, clk, rst_n, !accept, !done)
    `WFPQ_ASSERT_NEXT(a_clear_empties, clk, rst_n, do_clear, total_count == '0 && !pop_valid)
    `WFPQ_ASSERT_NOW(a_total_matches_fill, clk, rst_n, 1'b1, total_reg == CNT_W'(fill_reg[CLS_LOW]) + CNT_W'(fill_reg[CLS_NORMAL]) + CNT_W'(fill_reg[CLS_HIGH]) + CNT_W'(fill_reg[CLS_HIGHEST]))

endmodule

### verif/tb_weighted_four_level_priority_queue.sv
// Self-checking testbench for the weighted four-level priority queue scheduler.
// Needs wfpq_pkg and the weighted_four_level_priority_queue top level; nothing else.
`timescale 1ns / 1ps

module tb;

    import wfpq_pkg::*;

    localparam int QDEPTH = 64;
    localparam int TAGW   = 16;
    localparam int CNTW   = $clog2(4 * QDEPTH + 1);

    typedef struct packed {
        logic            pop_valid;
        logic [TAGW-1:0] tag;
        logic [1:0]      cls;
        logic            push_ok;
        logic [CNTW-1:0] total;
    } sched_result_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          opcode;
    logic [TAGW-1:0]     message_tag;
    logic [3:0]          priority_flags;
    logic                cfg_we;
    logic [CREDIT_W-1:0] cfg_wdata;
    logic                done;
    logic                pop_valid;
    logic [TAGW-1:0]     popped_tag;
    logic [1:0]          popped_class;
    logic                push_accepted;
    logic [CNTW-1:0]     total_count;

    logic [TAGW-1:0] tag_store [NUM_CLASSES][QDEPTH];
    int unsigned     head_ptr [NUM_CLASSES];
    int unsigned     fill_lvl [NUM_CLASSES];
    int unsigned     credit_highest;
    int unsigned     credit_high;
    int unsigned     credit_normal;
    int unsigned     burst_limit;

    sched_result_t   pending_results [$];
    sched_result_t   oldest;
    int              error_count;
    bit              sender_idles;

    weighted_four_level_priority_queue #(
        .QUEUE_DEPTH (QDEPTH),
        .TAG_WIDTH   (TAGW)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .message_tag    (message_tag),
        .priority_flags (priority_flags),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .done           (done),
        .pop_valid      (pop_valid),
        .popped_tag     (popped_tag),
        .popped_class   (popped_class),
        .push_accepted  (push_accepted),
        .total_count    (total_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [TAGW-1:0] take_front(input int c);
        logic [TAGW-1:0] t;
        t = tag_store[c][head_ptr[c]];
        head_ptr[c] = (head_ptr[c] + 1) % QDEPTH;
        fill_lvl[c] = fill_lvl[c] - 1;
        return t;
    endfunction

    function automatic bit serve_credited(output logic [TAGW-1:0] t, output cls_t c);
        if (credit_highest > 0 && fill_lvl[CLS_HIGHEST] > 0)
        begin
            t = take_front(CLS_HIGHEST);
            c = CLS_HIGHEST;
            credit_highest = credit_highest - 1;
            return 1'b1;
        end
        if (credit_high > 0 && fill_lvl[CLS_HIGH] > 0)
        begin
            t = take_front(CLS_HIGH);
            c = CLS_HIGH;
            credit_highest = burst_limit;
            credit_high = credit_high - 1;
            return 1'b1;
        end
        if (credit_normal > 0 && fill_lvl[CLS_NORMAL] > 0)
        begin
            t = take_front(CLS_NORMAL);
            c = CLS_NORMAL;
            credit_highest = burst_limit;
            credit_high = burst_limit;
            credit_normal = credit_normal - 1;
            return 1'b1;
        end
        t = '0;
        c = CLS_LOW;
        return 1'b0;
    endfunction

    function automatic void advance_scheduler(input op_t op, input logic [TAGW-1:0] tag,
                                              input logic [3:0] flags);
        sched_result_t r;
        int            sel;
        int unsigned   sum;
        logic [TAGW-1:0] t;
        cls_t          c;
        bit            got;
        r = '0;
        sel = -1;
        t = '0;
        c = CLS_LOW;
        case (op)
            OP_PUSH:
            begin
                if (flags[0])
                    sel = CLS_LOW;
                else if (flags[1])
                    sel = CLS_NORMAL;
                else if (flags[2])
                    sel = CLS_HIGH;
                else if (flags[3])
                    sel = CLS_HIGHEST;
                if (sel >= 0 && fill_lvl[sel] < QDEPTH)
                begin
                    tag_store[sel][(head_ptr[sel] + fill_lvl[sel]) % QDEPTH] = tag;
                    fill_lvl[sel] = fill_lvl[sel] + 1;
                    r.push_ok = 1'b1;
                end
            end
            OP_POP:
            begin
                got = serve_credited(t, c);
                if (!got)
                begin
                    credit_highest = burst_limit;
                    credit_high = burst_limit;
                    credit_normal = burst_limit;
                    if (fill_lvl[CLS_LOW] > 0)
                    begin
                        t = take_front(CLS_LOW);
                        c = CLS_LOW;
                        got = 1'b1;
                    end
                    else
                        got = serve_credited(t, c);
                end
                if (got)
                begin
                    r.pop_valid = 1'b1;
                    r.tag = t;
                    r.cls = c;
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < NUM_CLASSES; i++)
                begin
                    head_ptr[i] = 0;
                    fill_lvl[i] = 0;
                end
            end
            default:
            begin
            end
        endcase
        sum = 0;
        for (int i = 0; i < NUM_CLASSES; i++)
            sum = sum + fill_lvl[i];
        r.total = sum[CNTW-1:0];
        pending_results.push_back(r);
    endfunction

    task automatic compare_field(input string name, input logic [TAGW-1:0] want,
                                 input logic [TAGW-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no pending expectation");
                error_count++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                compare_field("pop_valid", TAGW'(oldest.pop_valid), TAGW'(pop_valid));
                compare_field("popped_tag", oldest.tag, popped_tag);
                compare_field("popped_class", TAGW'(oldest.cls), TAGW'(popped_class));
                compare_field("push_accepted", TAGW'(oldest.push_ok), TAGW'(push_accepted));
                compare_field("total_count", TAGW'(oldest.total), TAGW'(total_count));
            end
        end
    end

    task automatic send_op(input op_t op, input logic [TAGW-1:0] tag, input logic [3:0] flags);
        while (sender_idles && $urandom_range(0, 99) < 28)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        opcode <= op;
        message_tag <= tag;
        priority_flags <= flags;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        advance_scheduler(op, tag, flags);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_burst_credit(input logic [CREDIT_W-1:0] value);
        wait_results_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        burst_limit = (value == 0) ? 1 : value;
    endtask

    function automatic logic [3:0] random_flags();
        if ($urandom_range(0, 9) < 7)
            return 4'b0001 << $urandom_range(0, 3);
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic send_random(input int push_pct, input int pop_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            send_op(OP_PUSH, TAGW'($urandom_range(0, 65535)), random_flags());
        else if (r < push_pct + pop_pct)
            send_op(OP_POP, TAGW'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)));
        else if ($urandom_range(0, 9) == 0)
            send_op(OP_CLEAR, TAGW'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)));
        else
            send_op(OP_NOP, TAGW'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)));
    endtask

    task automatic test_directed();
        send_op(OP_POP, 16'h0000, 4'h0);
        send_op(OP_NOP, 16'hFFFF, 4'hF);
        send_op(OP_CLEAR, 16'h1234, 4'h5);
        send_op(OP_PUSH, 16'hBEEF, 4'h0);
        send_op(OP_PUSH, 16'hFFFF, 4'hF);
        send_op(OP_PUSH, 16'h0000, 4'b0010);
        send_op(OP_PUSH, 16'hAAAA, 4'b1110);
        send_op(OP_PUSH, 16'h5555, 4'b0100);
        send_op(OP_PUSH, 16'h8001, 4'b1100);
        send_op(OP_PUSH, 16'h7FFE, 4'b1000);
        send_op(OP_PUSH, 16'h0001, 4'b1000);
        repeat (8)
            send_op(OP_POP, 16'hFFFF, 4'hF);
        send_op(OP_PUSH, 16'h0F0F, 4'b1000);
        send_op(OP_PUSH, 16'hF0F0, 4'b0001);
        send_op(OP_CLEAR, 16'h0000, 4'h0);
        send_op(OP_POP, 16'h0000, 4'h0);
    endtask

    task automatic test_full_queues();
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            repeat (QDEPTH + 1)
                send_op(OP_PUSH, TAGW'($urandom_range(0, 65535)),
                        4'(1 << c) | (4'($urandom_range(0, 15)) & ~4'((2 << c) - 1)));
        end
        send_op(OP_PUSH, 16'h1111, 4'h0);
        repeat (4 * QDEPTH + 1)
            send_op(OP_POP, 16'h0000, 4'h0);
        repeat (40)
            send_op(OP_PUSH, TAGW'($urandom_range(0, 65535)), random_flags());
        send_op(OP_CLEAR, 16'hFFFF, 4'hF);
        send_op(OP_POP, 16'h0000, 4'h0);
    endtask

    task automatic test_credit_settings();
        logic [CREDIT_W-1:0] settings [6];
        settings = '{8'd1, 8'd255, 8'd0, 8'd2, 8'($urandom_range(3, 254)), CREDIT_RESET};
        foreach (settings[i])
        begin
            write_burst_credit(settings[i]);
            repeat (40)
                send_random(90, 10);
            repeat (80)
                send_random(45, 50);
        end
    endtask

    task automatic test_random_traffic();
        repeat (80)
            send_random(60, 35);
        repeat (60)
            send_random(30, 65);
        wait_results_drained();
        sender_idles = 1'b0;
        repeat (120)
            send_random(50, 45);
        sender_idles = 1'b1;
        repeat (80)
            send_random(65, 30);
        repeat (60)
            send_random(35, 60);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_NOP;
        message_tag = '0;
        priority_flags = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        error_count = 0;
        sender_idles = 1'b1;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            head_ptr[i] = 0;
            fill_lvl[i] = 0;
        end
        burst_limit = CREDIT_RESET;
        credit_highest = CREDIT_RESET;
        credit_high = CREDIT_RESET;
        credit_normal = CREDIT_RESET;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full_queues();
        test_credit_settings();
        test_random_traffic();

        wait_results_drained();
        repeat (4)
            @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/wfpq_pkg.sv
src/weighted_four_level_priority_queue.sv
verif/tb_weighted_four_level_priority_queue.sv
